// ----- src/life_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_pkg
// Shared types and constants of the toroidal life engine.
// ----------------------------------------------------------------------------
package life_pkg;

    // Grid capacity
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;

    // Row address, column index and size-count widths
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b1;
    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 7'd64;

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    // Life rule: neighbor totals
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;
    localparam logic [3:0] BIRTH_COUNT  = 4'd3;

    typedef logic [MAX_COLUMNS-1:0] t_row;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] cell_row;
        logic [5:0] cell_column;
        logic       cell_value;
    } t_req_item;

    typedef struct packed {
        logic read_value;
        logic request_done;
    } t_result;

endpackage

// ----- src/life_cellular_automaton_torus_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_torus_unit
// Toroidal life grid held in one row-wide memory; cell write/read and
// in-place generation step with a three-row window.
// ----------------------------------------------------------------------------
// Cell write/read: the row is read into a register, then the result is registered;
//   one request at a time. Generation: the step reads one memory row per cycle
//   and writes each new row back on the same port pair; S_LAST writes the last row.
// Reset returns the control registers to their reset values, then sweeps the grid
//   to dead with busy high. Results are strobed for one cycle; the receiver cannot stall.
module life_cellular_automaton_torus_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  life_pkg::t_req_item                i_req,
    output logic                               o_result_stb,
    output life_pkg::t_result                  o_result,
    input  logic                               i_cfg_we,
    input  logic [life_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [life_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CELL  = 5'b00100,
        S_GEN   = 5'b01000,
        S_LAST  = 5'b10000
    } t_state;

    // Grid memory: one word per row, bit c is column c
    life_pkg::t_row mem [life_pkg::MAX_ROWS];

    t_state                         r_state, n_state;
    logic [life_pkg::ROW_W-1:0]     r_clr, n_clr;
    logic [life_pkg::RCNT_W-1:0]    r_k, n_k;
    logic [life_pkg::RCNT_W-1:0]    r_kd, n_kd;
    logic                           r_issue, n_issue;
    logic                           r_dv, n_dv;
    life_pkg::t_req_item            r_req, n_req;
    life_pkg::t_row                 r_prev, n_prev;
    life_pkg::t_row                 r_cur, n_cur;
    life_pkg::t_row                 r_row0, n_row0;
    life_pkg::t_row                 r_rd_data;
    logic                           r_stb, n_stb;
    life_pkg::t_result              r_res, n_res;
    logic [life_pkg::CFG_DATA_W-1:0] r_grid_rows, r_grid_columns;

    logic                           wr_en;
    logic [life_pkg::ROW_W-1:0]     wr_addr;
    life_pkg::t_row                 wr_data;
    logic [life_pkg::ROW_W-1:0]     rd_addr;

    logic [life_pkg::RCNT_W-1:0]    nr;
    logic [life_pkg::CCNT_W-1:0]    nc;
    logic [life_pkg::ROW_W-1:0]     nr_m1;
    logic [life_pkg::COL_W-1:0]     nc_m1;
    logic                           cell_inside;
    logic [life_pkg::COL_W-1:0]     cell_col;
    life_pkg::t_row                 win_next;
    life_pkg::t_row                 gen_row;

    // Clamp the configured sizes to 1..max
    always_comb begin
        if (r_grid_rows == '0) begin
            nr = life_pkg::RCNT_W'(1);
        end else if (32'(r_grid_rows) > life_pkg::MAX_ROWS) begin
            nr = life_pkg::RCNT_W'(life_pkg::MAX_ROWS);
        end else begin
            nr = life_pkg::RCNT_W'(r_grid_rows);
        end
        if (r_grid_columns == '0) begin
            nc = life_pkg::CCNT_W'(1);
        end else if (32'(r_grid_columns) > life_pkg::MAX_COLUMNS) begin
            nc = life_pkg::CCNT_W'(life_pkg::MAX_COLUMNS);
        end else begin
            nc = life_pkg::CCNT_W'(r_grid_columns);
        end
    end

    assign nr_m1 = life_pkg::ROW_W'(nr - 1'b1);
    assign nc_m1 = life_pkg::COL_W'(nc - 1'b1);
    assign cell_col = life_pkg::COL_W'(r_req.cell_column);
    assign cell_inside = (32'(r_req.cell_row) < 32'(nr)) &&
                         (32'(r_req.cell_column) < 32'(nc));

    // Row below the window: fresh memory data, or saved row 0 for the last row
    assign win_next = (r_state == S_LAST) ? r_row0 : r_rd_data;

    // Apply the rule across one row with column wrap at the size in use
    always_comb begin
        logic [life_pkg::COL_W-1:0] lc;
        logic [life_pkg::COL_W-1:0] rc;
        logic [3:0]                 total;
        gen_row = r_cur;
        for (int c = 0; c < life_pkg::MAX_COLUMNS; c++) begin
            lc = (c == 0) ? nc_m1 : life_pkg::COL_W'(c - 1);
            rc = (life_pkg::COL_W'(c) == nc_m1) ? '0 : life_pkg::COL_W'(c + 1);
            total = {3'b000, r_prev[lc]} + {3'b000, r_prev[c]} + {3'b000, r_prev[rc]}
                  + {3'b000, r_cur[lc]}  + {3'b000, r_cur[rc]}
                  + {3'b000, win_next[lc]} + {3'b000, win_next[c]}
                  + {3'b000, win_next[rc]};
            if (32'(c) < 32'(nc)) begin
                if (r_cur[c]) begin
                    gen_row[c] = (total == life_pkg::SURVIVE_LOW) ||
                                 (total == life_pkg::SURVIVE_HIGH);
                end else begin
                    gen_row[c] = (total == life_pkg::BIRTH_COUNT);
                end
            end
        end
    end

    // Sequencer: clear sweep, cell access, row-streaming generation step
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_k     = r_k;
        n_kd    = r_kd;
        n_issue = r_issue;
        n_dv    = 1'b0;
        n_req   = r_req;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_row0  = r_row0;
        n_stb   = 1'b0;
        n_res   = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_addr = '0;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == life_pkg::ROW_W'(life_pkg::MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    if (i_req.req_type == life_pkg::REQ_STEP) begin
                        n_k     = '0;
                        n_issue = 1'b1;
                        n_state = S_GEN;
                    end else begin
                        rd_addr = life_pkg::ROW_W'(i_req.cell_row);
                        n_state = S_CELL;
                    end
                end
            end
            S_CELL: begin
                n_stb   = 1'b1;
                n_state = S_IDLE;
                case (r_req.req_type)
                    life_pkg::REQ_WRITE: begin
                        n_res.request_done = 1'b1;
                        if (cell_inside) begin
                            wr_en   = 1'b1;
                            wr_addr = life_pkg::ROW_W'(r_req.cell_row);
                            wr_data = r_rd_data;
                            wr_data[cell_col] = r_req.cell_value;
                        end
                    end
                    life_pkg::REQ_READ: begin
                        n_res.request_done = 1'b1;
                        n_res.read_value   = cell_inside & r_rd_data[cell_col];
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_GEN: begin
                // Issue rows: last row first, then rows 0 .. nr-1
                if (r_issue) begin
                    rd_addr = (r_k == '0) ? nr_m1 : life_pkg::ROW_W'(r_k - 1'b1);
                    n_k = r_k + 1'b1;
                    if (r_k == nr) begin
                        n_issue = 1'b0;
                    end
                end
                n_dv = r_issue;
                n_kd = r_k;
                // Shift the window; write a new row once its lower row is in
                if (r_dv) begin
                    n_prev = r_cur;
                    n_cur  = r_rd_data;
                    if (r_kd == life_pkg::RCNT_W'(1)) begin
                        n_row0 = r_rd_data;
                    end
                    if (r_kd >= life_pkg::RCNT_W'(2)) begin
                        wr_en   = 1'b1;
                        wr_addr = life_pkg::ROW_W'(r_kd - life_pkg::RCNT_W'(2));
                        wr_data = gen_row;
                    end
                    if (r_kd == nr) begin
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                wr_en   = 1'b1;
                wr_addr = nr_m1;
                wr_data = gen_row;
                n_stb   = 1'b1;
                n_res.request_done = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Grid memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_k            <= '0;
            r_kd           <= '0;
            r_issue        <= 1'b0;
            r_dv           <= 1'b0;
            r_stb          <= 1'b0;
            r_grid_rows    <= life_pkg::GRID_SIZE_RESET;
            r_grid_columns <= life_pkg::GRID_SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_k     <= n_k;
            r_kd    <= n_kd;
            r_issue <= n_issue;
            r_dv    <= n_dv;
            r_stb   <= n_stb;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    life_pkg::CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data;
                    life_pkg::CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                    default: begin
                        r_grid_rows <= r_grid_rows;
                    end
                endcase
            end
        end
    end

    // Payload: request, row window, result
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_row0 <= n_row0;
        r_res  <= n_res;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_result_stb = r_stb;
    assign o_result     = r_res;

endmodule

// ----- test/life_cellular_automaton_torus_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the toroidal life engine: cell writes, cell reads and generation
// steps over a range of grid sizes. A shadow grid predicts every result.
// A queue-fed driver issues requests and size changes, and a monitor compares
// each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          RANDOM_ITEMS  = 850;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 80;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_CONFIG,
        OP_PAUSE
    } t_op_kind;

    typedef struct {
        t_op_kind                                 kind;
        life_pkg::t_req_item                      item;
        logic [life_pkg::CFG_IDX_W-1:0]           cfg_idx;
        logic [life_pkg::CFG_DATA_W-1:0]          cfg_data;
        bit                                       eager;
    } t_pending_op;

    // DUT connections
    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             start      = 1'b0;
    logic                             busy;
    life_pkg::t_req_item              i_req      = '0;
    logic                             o_result_stb;
    life_pkg::t_result                o_result;
    logic                             i_cfg_we   = 1'b0;
    logic [life_pkg::CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [life_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Stimulus, prediction and run control
    t_pending_op                      pending_ops [$];
    life_pkg::t_result                pending_outcomes [$];
    life_pkg::t_row                   shadow_grid [life_pkg::MAX_ROWS];
    logic [life_pkg::CFG_DATA_W-1:0]  shadow_rows;
    logic [life_pkg::CFG_DATA_W-1:0]  shadow_cols;
    int                               mismatch_count = 0;
    int                               cycle_count    = 0;
    int                               in_flight      = 0;
    int                               settle_count   = 0;
    bit                               draining       = 1'b0;
    bit                               stimulus_sent  = 1'b0;

    life_cellular_automaton_torus_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_result_stb (o_result_stb),
        .o_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Clamp a size register to the range the grid supports
    function automatic int effective_size(input logic [life_pkg::CFG_DATA_W-1:0] raw,
                                          input int limit);
        if (raw < 1) begin
            return 1;
        end
        if (raw > limit) begin
            return limit;
        end
        return int'(raw);
    endfunction

    // Apply one request to the shadow grid and return its result
    function automatic life_pkg::t_result grid_request_outcome(
        input life_pkg::t_req_item req);
        life_pkg::t_result outcome;
        life_pkg::t_row    next_rows [life_pkg::MAX_ROWS];
        int                n_rows;
        int                n_cols;
        int                total;
        int                r;
        int                c;
        int                dr;
        int                dc;
        logic              in_grid;
        outcome = '0;
        n_rows  = effective_size(shadow_rows, life_pkg::MAX_ROWS);
        n_cols  = effective_size(shadow_cols, life_pkg::MAX_COLUMNS);
        in_grid = (req.cell_row < n_rows) && (req.cell_column < n_cols);
        case (req.req_type)
            life_pkg::REQ_WRITE: begin
                if (in_grid) begin
                    shadow_grid[req.cell_row][req.cell_column] = req.cell_value;
                end
                outcome.request_done = 1'b1;
            end
            life_pkg::REQ_READ: begin
                if (in_grid) begin
                    outcome.read_value = shadow_grid[req.cell_row][req.cell_column];
                end
                outcome.request_done = 1'b1;
            end
            life_pkg::REQ_STEP: begin
                // Cells outside the size in use keep their contents
                next_rows = shadow_grid;
                for (r = 0; r < n_rows; r++) begin
                    for (c = 0; c < n_cols; c++) begin
                        total = 0;
                        for (dr = 0; dr < 3; dr++) begin
                            for (dc = 0; dc < 3; dc++) begin
                                if (dr != 1 || dc != 1) begin
                                    total += shadow_grid[(r + n_rows + dr - 1) % n_rows]
                                                        [(c + n_cols + dc - 1) % n_cols];
                                end
                            end
                        end
                        if (shadow_grid[r][c]) begin
                            next_rows[r][c] = (total == life_pkg::SURVIVE_LOW) ||
                                              (total == life_pkg::SURVIVE_HIGH);
                        end else begin
                            next_rows[r][c] = (total == life_pkg::BIRTH_COUNT);
                        end
                    end
                end
                shadow_grid = next_rows;
                outcome.request_done = 1'b1;
            end
            default: begin
                // Unknown request: no change, no done flag
            end
        endcase
        return outcome;
    endfunction

    task automatic push_request(input logic [1:0] kind, input int row, input int col,
                                input logic value, input bit eager);
        t_pending_op op;
        op.kind                 = OP_REQUEST;
        op.item.req_type        = kind;
        op.item.cell_row        = 6'(row);
        op.item.cell_column     = 6'(col);
        op.item.cell_value      = value;
        op.cfg_idx              = '0;
        op.cfg_data             = '0;
        op.eager                = eager;
        pending_ops.push_back(op);
    endtask

    task automatic push_config(input logic [life_pkg::CFG_IDX_W-1:0] idx, input int data);
        t_pending_op op;
        op.kind     = OP_CONFIG;
        op.item     = '0;
        op.cfg_idx  = idx;
        op.cfg_data = 7'(data);
        op.eager    = 1'b0;
        pending_ops.push_back(op);
    endtask

    // Hold the sender until every outstanding result is back and the block is idle
    task automatic push_pause();
        t_pending_op op;
        op.kind     = OP_PAUSE;
        op.item     = '0;
        op.cfg_idx  = '0;
        op.cfg_data = '0;
        op.eager    = 1'b0;
        pending_ops.push_back(op);
    endtask

    // Mostly small grids, with the clamped and full extremes now and then
    function automatic int pick_grid_size();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 64;
            4:       return $urandom_range(127, 65);
            5:       return $urandom_range(64, 17);
            default: return $urandom_range(16, 3);
        endcase
    endfunction

    // Driver: issue queued transfers, size writes and pauses
    always @(posedge i_clk) begin : driver
        logic        accepted;
        logic        drive_start;
        logic        drive_we;
        t_pending_op op;
        if (i_rst_n) begin
            accepted    = start && !busy;
            in_flight   = in_flight + int'(accepted) - int'(o_result_stb);
            drive_start = start && !accepted;
            drive_we    = 1'b0;
            if (!drive_start) begin
                if (draining) begin
                    if (in_flight <= 0 && !busy) begin
                        if (settle_count >= SETTLE_CYCLES) begin
                            draining = 1'b0;
                        end else begin
                            settle_count++;
                        end
                    end else begin
                        settle_count = 0;
                    end
                end else if (pending_ops.size() == 0) begin
                    stimulus_sent = 1'b1;
                end else begin
                    case (pending_ops[0].kind)
                        OP_REQUEST: begin
                            if (pending_ops[0].eager || $urandom_range(99) >= 25) begin
                                op          = pending_ops.pop_front();
                                drive_start = 1'b1;
                                i_req      <= op.item;
                            end
                        end
                        OP_CONFIG: begin
                            op          = pending_ops.pop_front();
                            drive_we    = 1'b1;
                            i_cfg_idx  <= op.cfg_idx;
                            i_cfg_data <= op.cfg_data;
                        end
                        default: begin
                            op           = pending_ops.pop_front();
                            draining     = 1'b1;
                            settle_count = 0;
                        end
                    endcase
                end
            end
            start    <= drive_start;
            i_cfg_we <= drive_we;
        end
    end

    // Monitor: check strobed results, then track size writes and new transfers
    always @(posedge i_clk) begin : monitor
        life_pkg::t_result expected;
        int                r;
        if (!i_rst_n) begin
            for (r = 0; r < life_pkg::MAX_ROWS; r++) begin
                shadow_grid[r] = '0;
            end
            shadow_rows = life_pkg::GRID_SIZE_RESET;
            shadow_cols = life_pkg::GRID_SIZE_RESET;
        end else begin
            if (o_result_stb) begin
                if (pending_outcomes.size() == 0) begin
                    $error("unexpected result: read_value %0b, request_done %0b",
                           o_result.read_value, o_result.request_done);
                    mismatch_count++;
                end else begin
                    expected = pending_outcomes.pop_front();
                    if (o_result.read_value !== expected.read_value) begin
                        $error("read_value: expected %0b, got %0b",
                               expected.read_value, o_result.read_value);
                        mismatch_count++;
                    end
                    if (o_result.request_done !== expected.request_done) begin
                        $error("request_done: expected %0b, got %0b",
                               expected.request_done, o_result.request_done);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    life_pkg::CFG_GRID_ROWS:    shadow_rows = i_cfg_data;
                    life_pkg::CFG_GRID_COLUMNS: shadow_cols = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                pending_outcomes.push_back(grid_request_outcome(i_req));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("life_cellular_automaton_torus_unit: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int random_items;
        int phase;
        int phase_len;
        int seed_len;
        int rows_raw;
        int cols_raw;
        int n_rows;
        int n_cols;
        int roll;
        int row;
        int col;
        int k;
        bit eager;
        logic [1:0] kind;

        // Wait out the clearing sweep after reset
        push_pause();

        // Full grid: corners dead after reset, blinker across the wrap seam
        push_request(life_pkg::REQ_READ, 0, 0, 1'b0, 1'b0);
        push_request(life_pkg::REQ_READ, 63, 63, 1'b0, 1'b0);
        push_request(life_pkg::REQ_WRITE, 0, 63, 1'b1, 1'b0);
        push_request(life_pkg::REQ_WRITE, 0, 0, 1'b1, 1'b0);
        push_request(life_pkg::REQ_WRITE, 0, 1, 1'b1, 1'b0);
        push_request(life_pkg::REQ_STEP, 0, 0, 1'b0, 1'b0);
        push_request(life_pkg::REQ_READ, 63, 0, 1'b0, 1'b0);
        push_request(life_pkg::REQ_READ, 1, 0, 1'b0, 1'b0);
        push_request(life_pkg::REQ_READ, 0, 63, 1'b0, 1'b0);
        push_request(REQ_UNKNOWN, 63, 63, 1'b1, 1'b0);
        push_request(life_pkg::REQ_WRITE, 63, 63, 1'b1, 1'b0);
        push_request(life_pkg::REQ_READ, 63, 63, 1'b0, 1'b0);

        // Zero rows clamps to one, oversize columns clamp to the maximum;
        // with one row every wrapped neighbor row is the same row
        push_pause();
        push_config(life_pkg::CFG_GRID_ROWS, 0);
        push_config(life_pkg::CFG_GRID_COLUMNS, 127);
        push_request(life_pkg::REQ_WRITE, 1, 5, 1'b1, 1'b0);
        push_request(life_pkg::REQ_READ, 1, 5, 1'b0, 1'b0);
        push_request(life_pkg::REQ_WRITE, 0, 4, 1'b1, 1'b0);
        push_request(life_pkg::REQ_WRITE, 0, 6, 1'b1, 1'b0);
        push_request(life_pkg::REQ_STEP, 0, 0, 1'b0, 1'b0);
        push_request(life_pkg::REQ_READ, 0, 5, 1'b0, 1'b0);

        // Two by two grid: neighbors repeat in both directions
        push_pause();
        push_config(life_pkg::CFG_GRID_ROWS, 2);
        push_config(life_pkg::CFG_GRID_COLUMNS, 2);
        push_request(life_pkg::REQ_WRITE, 0, 0, 1'b1, 1'b0);
        push_request(life_pkg::REQ_WRITE, 1, 1, 1'b1, 1'b0);
        push_request(life_pkg::REQ_STEP, 0, 0, 1'b0, 1'b0);
        push_request(life_pkg::REQ_READ, 0, 1, 1'b0, 1'b0);

        // Enlarge again: cells left outside kept their contents
        push_pause();
        push_config(life_pkg::CFG_GRID_ROWS, 64);
        push_config(life_pkg::CFG_GRID_COLUMNS, 64);
        push_request(life_pkg::REQ_READ, 63, 63, 1'b0, 1'b0);

        // Random phases: resize, seed a pattern, then mix reads, writes and steps
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            rows_raw = pick_grid_size();
            cols_raw = pick_grid_size();
            push_pause();
            push_config(life_pkg::CFG_GRID_ROWS, rows_raw);
            push_config(life_pkg::CFG_GRID_COLUMNS, cols_raw);
            n_rows    = effective_size(7'(rows_raw), life_pkg::MAX_ROWS);
            n_cols    = effective_size(7'(cols_raw), life_pkg::MAX_COLUMNS);
            eager     = (phase == 4);
            phase_len = $urandom_range(90, 30);
            if (phase_len > RANDOM_ITEMS - random_items) begin
                phase_len = RANDOM_ITEMS - random_items;
            end
            seed_len  = $urandom_range(20, 4);
            for (k = 0; k < phase_len; k++) begin
                roll = $urandom_range(99);
                if (k < seed_len || roll < 30) begin
                    kind = life_pkg::REQ_WRITE;
                end else if (roll < 62) begin
                    kind = life_pkg::REQ_READ;
                end else if (roll < 93) begin
                    kind = life_pkg::REQ_STEP;
                end else begin
                    kind = REQ_UNKNOWN;
                end
                if ($urandom_range(9) == 0) begin
                    row = $urandom_range(63);
                    col = $urandom_range(63);
                end else begin
                    row = $urandom_range(n_rows - 1);
                    col = $urandom_range(n_cols - 1);
                end
                push_request(kind, row, col, 1'($urandom_range(3) != 0), eager);
                if ($urandom_range(99) < 3) begin
                    push_pause();
                end
            end
            random_items += phase_len;
            phase++;
        end
        push_pause();

        // Release reset and let the driver run
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!stimulus_sent) begin
            @(posedge i_clk);
        end
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("life_cellular_automaton_torus_unit: match");
        end else begin
            $display("life_cellular_automaton_torus_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/life_pkg.sv
src/life_cellular_automaton_torus_unit.sv
test/life_cellular_automaton_torus_unit_tb.sv
